/* hdl/fk_pkg.sv */
// ----------------------------------------------------------------------------
// fk_pkg
// shared types, constants and fixed-point helpers of the arm kinematics block
// ----------------------------------------------------------------------------
package fk_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_D0 = 3'd0,
    REG_D1 = 3'd1,
    REG_D2 = 3'd2,
    REG_D3 = 3'd3,
    REG_D4 = 3'd4,
    REG_D5 = 3'd5,
    REG_L0 = 3'd6,
    REG_L1 = 3'd7
  } reg_idx_e;

  // geometry registers, 1/256 mm
  typedef struct packed {
    logic signed [20:0] d0;
    logic signed [20:0] d1;
    logic signed [20:0] d2;
    logic signed [20:0] d3;
    logic signed [20:0] d4;
    logic signed [20:0] d5;
    logic signed [20:0] l0;
    logic signed [20:0] l1;
  } geom_t;

  // q16 sine / cosine of the joint angles and the folded angle sums
  typedef struct packed {
    logic signed [17:0] s0;
    logic signed [17:0] c0;
    logic signed [17:0] s1;
    logic signed [17:0] c1;
    logic signed [17:0] s4;
    logic signed [17:0] c4;
    logic signed [17:0] s5;
    logic signed [17:0] c5;
    logic signed [17:0] sb;
    logic signed [17:0] cb;
    logic signed [17:0] sc;
    logic signed [17:0] cc;
  } trig_t;

  // tool position and the vectors fed to the atan2 lanes
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [19:0] sphi;
    logic signed [19:0] cphi;
    logic signed [19:0] st;
    logic signed [19:0] ct;
    logic signed [19:0] sp;
    logic               singular;
  } pose_t;

  localparam logic signed [17:0] KGain     = 18'sd39797;
  localparam logic signed [25:0] HalfTurnZ = 26'sd11796480;

  // cordic arctangent table, 1/65536 degree
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // q16 product rounded half up
  function automatic logic signed [17:0] mq(input logic signed [17:0] a,
                                            input logic signed [17:0] b);
    logic signed [35:0] pr;
    pr = 36'(a) * 36'(b) + 36'sd32768;
    return pr[33:16];
  endfunction

  // wrap an angle in 1/256 degree into [-180, 180)
  function automatic logic signed [16:0] reduce_angle(input logic signed [19:0] a);
    logic signed [19:0] v;
    v = a;
    for (int k = 0; k < 5; k++) begin
      if (v >= 20'sd46080) begin
        v = v - 20'sd92160;
      end else if (v < -20'sd46080) begin
        v = v + 20'sd92160;
      end
    end
    return v[16:0];
  endfunction

  // 1/65536 degree to 1/256 degree, rounded and clamped to +-180
  function automatic logic signed [16:0] deg_out(input logic signed [25:0] z);
    logic signed [26:0] t;
    logic signed [18:0] v;
    t = 27'(z) + 27'sd128;
    v = t[26:8];
    if (v > 19'sd46080) begin
      v = 19'sd46080;
    end else if (v < -19'sd46080) begin
      v = -19'sd46080;
    end
    return v[16:0];
  endfunction

  // length times q16 accumulator to 1/256 mm, rounded and saturated
  function automatic logic signed [23:0] pos_out(input logic signed [43:0] acc);
    logic signed [44:0] t;
    logic signed [28:0] v;
    t = 45'(acc) + 45'sd32768;
    v = t[44:16];
    if (v > 29'sd8388607) begin
      v = 29'sd8388607;
    end else if (v < -29'sd8388608) begin
      v = -29'sd8388608;
    end
    return v[23:0];
  endfunction

endpackage

/* hdl/six_axis_arm_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// six_axis_arm_forward_kinematics
// tool position and orientation of a six-axis arm from its joint angles
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat carries six joint angles in 1/256 degree, taken
//   when in_valid_i is high and in_stall_o is low
//   output channel: one beat carries x, y, z in 1/256 mm, phi, psi, theta in
//   1/256 degree and the singular flag, taken when out_valid_o is high and
//   out_stall_i is low
//   config port: cfg_index_i selects d0..d5, l0, l1; written when cfg_valid_i
//   and cfg_ready_o are high; cfg_ready_o is always high; write only when idle
// latency: 3 * CORDIC_ITERATIONS + 7 cycles from input beat to output beat
// throughput: one beat per CORDIC_ITERATIONS + 1 cycles, set by the iterative
//   cordic lanes; the sine, atan2 and psi stages each hold a different beat
// reset: clears all handshake state and the geometry registers to zero
// stall: a stalled result waits in the output register while the stages
//   behind it keep working until each holds a finished beat
// ----------------------------------------------------------------------------
module six_axis_arm_forward_kinematics #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [17:0] joint_angle_0_i,
  input  logic signed [17:0] joint_angle_1_i,
  input  logic signed [17:0] joint_angle_2_i,
  input  logic signed [17:0] joint_angle_3_i,
  input  logic signed [17:0] joint_angle_4_i,
  input  logic signed [17:0] joint_angle_5_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic signed [23:0] pos_z_o,
  output logic signed [16:0] orient_phi_o,
  output logic signed [16:0] orient_psi_o,
  output logic signed [16:0] orient_theta_o,
  output logic               singular_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [20:0]        cfg_data_i
);
  import fk_pkg::*;

  // geometry registers
  geom_t geom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_D0:  geom_q.d0 <= cfg_data_i;
        REG_D1:  geom_q.d1 <= cfg_data_i;
        REG_D2:  geom_q.d2 <= cfg_data_i;
        REG_D3:  geom_q.d3 <= cfg_data_i;
        REG_D4:  geom_q.d4 <= cfg_data_i;
        REG_D5:  geom_q.d5 <= cfg_data_i;
        REG_L0:  geom_q.l0 <= cfg_data_i;
        REG_L1:  geom_q.l1 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // six sine/cosine lanes: q0, q1, q4, q5, q1-q2, q1-q2+q3
  localparam int NumLanes = 6;

  logic signed [19:0] lane_angle [NumLanes];
  logic signed [17:0] lane_sin   [NumLanes];
  logic signed [17:0] lane_cos   [NumLanes];
  logic [NumLanes-1:0] lane_in_ready, lane_out_valid;
  logic               lanes_ready, lanes_valid, lanes_go;
  logic               merge_in_ready;
  logic signed [19:0] angle_b;

  assign angle_b       = 20'(joint_angle_1_i) - 20'(joint_angle_2_i);
  assign lane_angle[0] = 20'(joint_angle_0_i);
  assign lane_angle[1] = 20'(joint_angle_1_i);
  assign lane_angle[2] = 20'(joint_angle_4_i);
  assign lane_angle[3] = 20'(joint_angle_5_i);
  assign lane_angle[4] = angle_b;
  assign lane_angle[5] = angle_b + 20'(joint_angle_3_i);

  // all lanes start together and finish together
  assign lanes_ready = &lane_in_ready;
  assign lanes_valid = &lane_out_valid;
  assign lanes_go    = in_valid_i && lanes_ready;
  assign in_stall_o  = !lanes_ready;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    fk_sincos_lane #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (lanes_go),
      .in_ready_o  (lane_in_ready[g]),
      .angle_i     (lane_angle[g]),
      .out_valid_o (lane_out_valid[g]),
      .out_ready_i (merge_in_ready && lanes_valid),
      .sin_o       (lane_sin[g]),
      .cos_o       (lane_cos[g])
    );
  end

  trig_t trig;
  always_comb begin
    trig.s0 = lane_sin[0];
    trig.c0 = lane_cos[0];
    trig.s1 = lane_sin[1];
    trig.c1 = lane_cos[1];
    trig.s4 = lane_sin[2];
    trig.c4 = lane_cos[2];
    trig.s5 = lane_sin[3];
    trig.c5 = lane_cos[3];
    trig.sb = lane_sin[4];
    trig.cb = lane_cos[4];
    trig.sc = lane_sin[5];
    trig.cc = lane_cos[5];
  end

  // merge: products and sums of the lane results
  pose_t pose;
  logic  merge_valid, merge_out_ready;

  fk_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lanes_valid),
    .in_ready_o  (merge_in_ready),
    .trig_i      (trig),
    .geom_i      (geom_q),
    .out_valid_o (merge_valid),
    .out_ready_i (merge_out_ready),
    .pose_o      (pose)
  );

  // atan2 stage: phi and theta side by side
  logic               phi_rdy, th_rdy, phi_v, th_v, a_go, a_done, psi_rdy;
  logic signed [16:0] phi_deg, th_deg;
  logic signed [23:0] th_mag;
  logic signed [23:0] pos_x_a_q, pos_y_a_q, pos_z_a_q;
  logic signed [19:0] sp_a_q;
  logic               sing_a_q;

  assign merge_out_ready = phi_rdy && th_rdy;
  assign a_go            = merge_valid && merge_out_ready;
  assign a_done          = phi_v && th_v;

  fk_atan_lane #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_phi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_go),
    .in_ready_o  (phi_rdy),
    .x_i         (24'(pose.cphi)),
    .y_i         (24'(pose.sphi)),
    .out_valid_o (phi_v),
    .out_ready_i (psi_rdy && a_done),
    .deg_o       (phi_deg),
    .mag_o       ()
  );

  fk_atan_lane #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_theta (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_go),
    .in_ready_o  (th_rdy),
    .x_i         (24'(pose.ct)),
    .y_i         (24'(pose.st)),
    .out_valid_o (th_v),
    .out_ready_i (psi_rdy && a_done),
    .deg_o       (th_deg),
    .mag_o       (th_mag)
  );

  // fields riding along with the atan2 stage
  always_ff @(posedge clk_i) begin
    if (a_go) begin
      pos_x_a_q <= pose.pos_x;
      pos_y_a_q <= pose.pos_y;
      pos_z_a_q <= pose.pos_z;
      sp_a_q    <= pose.sp;
      sing_a_q  <= pose.singular;
    end
  end

  // psi stage: divisor is the theta magnitude
  logic               b_go, psi_v, out_free;
  logic signed [16:0] psi_deg;
  logic signed [23:0] pos_x_b_q, pos_y_b_q, pos_z_b_q;
  logic signed [16:0] phi_b_q, th_b_q;
  logic               sing_b_q;

  assign b_go = a_done && psi_rdy;

  fk_atan_lane #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_psi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_done),
    .in_ready_o  (psi_rdy),
    .x_i         (th_mag),
    .y_i         (24'(sp_a_q)),
    .out_valid_o (psi_v),
    .out_ready_i (out_free),
    .deg_o       (psi_deg),
    .mag_o       ()
  );

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      pos_x_b_q <= pos_x_a_q;
      pos_y_b_q <= pos_y_a_q;
      pos_z_b_q <= pos_z_a_q;
      phi_b_q   <= phi_deg;
      th_b_q    <= th_deg;
      sing_b_q  <= sing_a_q;
    end
  end

  // output register
  logic out_valid_q;
  logic out_load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = psi_v && out_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= psi_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_o        <= pos_x_b_q;
      pos_y_o        <= pos_y_b_q;
      pos_z_o        <= pos_z_b_q;
      orient_phi_o   <= phi_b_q;
      orient_theta_o <= th_b_q;
      // singular pose: psi is forced to zero
      orient_psi_o   <= sing_b_q ? '0 : psi_deg;
      singular_o     <= sing_b_q;
    end
  end

endmodule

/* hdl/fk_sincos_lane.sv */
// ----------------------------------------------------------------------------
// fk_sincos_lane
// iterative rotation cordic, one angle in, q16 sine and cosine out
// ----------------------------------------------------------------------------
module fk_sincos_lane #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [19:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o
);
  import fk_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [4:0]         iter_q, iter_d;
  logic signed [19:0] x_q, x_d, y_q, y_d;
  logic signed [24:0] z_q, z_d;
  logic               neg_q, neg_d;
  logic signed [16:0] red, fold;
  logic               fneg;
  logic signed [24:0] at;
  logic               accept;

  assign in_ready_o  = !busy_q && (!done_q || out_ready_i);
  assign out_valid_o = done_q;
  assign accept      = in_valid_i && in_ready_o;
  assign at          = $signed({3'b000, atan_tab(iter_q)});

  // fold into the right half plane
  always_comb begin
    red  = reduce_angle(angle_i);
    fold = red;
    fneg = 1'b0;
    if (red > 17'sd23040) begin
      fold = red - 17'sd46080;
      fneg = 1'b1;
    end else if (red < -17'sd23040) begin
      fold = red + 17'sd46080;
      fneg = 1'b1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    neg_d  = neg_q;
    if (done_q && out_ready_i) begin
      done_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      iter_d = '0;
      x_d    = 20'(KGain);
      y_d    = '0;
      z_d    = {fold, 8'd0};
      neg_d  = fneg;
    end else if (busy_q) begin
      if (!z_q[24]) begin
        x_d = x_q - (y_q >>> iter_q);
        y_d = y_q + (x_q >>> iter_q);
        z_d = z_q - at;
      end else begin
        x_d = x_q + (y_q >>> iter_q);
        y_d = y_q - (x_q >>> iter_q);
        z_d = z_q + at;
      end
      iter_d = iter_q + 5'd1;
      if (iter_q == 5'(CORDIC_ITERATIONS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    neg_q  <= neg_d;
  end

  // clamp to unit range and undo the fold
  function automatic logic signed [17:0] clamp_unit(input logic signed [19:0] v);
    logic signed [19:0] t;
    t = v;
    if (t > 20'sd65536) begin
      t = 20'sd65536;
    end else if (t < -20'sd65536) begin
      t = -20'sd65536;
    end
    return t[17:0];
  endfunction

  always_comb begin
    sin_o = clamp_unit(y_q);
    cos_o = clamp_unit(x_q);
    if (neg_q) begin
      sin_o = -sin_o;
      cos_o = -cos_o;
    end
  end

endmodule

/* hdl/fk_atan_lane.sv */
// ----------------------------------------------------------------------------
// fk_atan_lane
// iterative vectoring cordic, atan2 in 1/256 degree and q16 magnitude
// ----------------------------------------------------------------------------
module fk_atan_lane #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] x_i,
  input  logic signed [23:0] y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] deg_o,
  output logic signed [23:0] mag_o
);
  import fk_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [4:0]         iter_q, iter_d;
  logic signed [25:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               zero_q, zero_d;
  logic signed [25:0] at;
  logic signed [43:0] mprod;
  logic               accept;

  assign in_ready_o  = !busy_q && (!done_q || out_ready_i);
  assign out_valid_o = done_q;
  assign accept      = in_valid_i && in_ready_o;
  assign at          = $signed({4'b0000, atan_tab(iter_q)});

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    zero_d = zero_q;
    if (done_q && out_ready_i) begin
      done_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      iter_d = '0;
      zero_d = (x_i == '0) && (y_i == '0);
      x_d    = 26'(x_i);
      y_d    = 26'(y_i);
      z_d    = '0;
      // left half plane: rotate by a half turn first
      if (x_i < 0) begin
        x_d = -26'(x_i);
        y_d = -26'(y_i);
        z_d = (y_i >= 0) ? HalfTurnZ : -HalfTurnZ;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + (y_q >>> iter_q);
        y_d = y_q - (x_q >>> iter_q);
        z_d = z_q + at;
      end else begin
        x_d = x_q - (y_q >>> iter_q);
        y_d = y_q + (x_q >>> iter_q);
        z_d = z_q - at;
      end
      iter_d = iter_q + 5'd1;
      if (iter_q == 5'(CORDIC_ITERATIONS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  // gain correction of the magnitude
  assign mprod = 44'(x_q) * 44'(KGain) + 44'sd32768;

  always_comb begin
    deg_o = zero_q ? '0 : deg_out(z_q);
    mag_o = zero_q ? '0 : mprod[39:16];
  end

endmodule

/* hdl/fk_merge.sv */
// ----------------------------------------------------------------------------
// fk_merge
// four-level product pipeline combining the lane results into pose terms
// ----------------------------------------------------------------------------
module fk_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fk_pkg::trig_t trig_i,
  input  fk_pkg::geom_t geom_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fk_pkg::pose_t pose_o
);
  import fk_pkg::*;

  logic signed [20:0] d0, d1, d2, d3, d4, d5, l0, l1;
  assign d0 = geom_i.d0;
  assign d1 = geom_i.d1;
  assign d2 = geom_i.d2;
  assign d3 = geom_i.d3;
  assign d4 = geom_i.d4;
  assign d5 = geom_i.d5;
  assign l0 = geom_i.l0;
  assign l1 = geom_i.l1;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_q || out_ready_i;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // level 1: trig products
  logic signed [17:0] m01_q, m02_q, m03_q, m04_q, m05_q, m06_q, m07_q, m08_q, m09_q;
  logic signed [17:0] m10_q, m11_q, p_q, m13_q, m14_q, m15_q, m16_q, m17_q, m18_q;
  logic signed [17:0] m19_q, s0_1q, c0_1q, c1_1q, cb_1q, cc_1q, sc_1q, s4_1q;
  logic signed [22:0] dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      m01_q <= mq(trig_i.c0, trig_i.s1);
      m02_q <= mq(trig_i.c0, trig_i.sb);
      m03_q <= mq(trig_i.c0, trig_i.sc);
      m04_q <= mq(trig_i.c4, trig_i.s0);
      m05_q <= mq(trig_i.c0, trig_i.s4);
      m06_q <= mq(trig_i.c0, trig_i.c4);
      m07_q <= mq(trig_i.s0, trig_i.s1);
      m08_q <= mq(trig_i.s0, trig_i.sb);
      m09_q <= mq(trig_i.s0, trig_i.sc);
      m10_q <= mq(trig_i.s0, trig_i.s4);
      m11_q <= mq(trig_i.s4, trig_i.sc);
      p_q   <= mq(trig_i.c4, trig_i.c5);
      m13_q <= mq(trig_i.c5, trig_i.cc);
      m14_q <= mq(trig_i.s5, trig_i.c4);
      m15_q <= mq(trig_i.s0, trig_i.s5);
      m16_q <= mq(trig_i.c0, trig_i.c5);
      m17_q <= mq(trig_i.c5, trig_i.s0);
      m18_q <= mq(trig_i.c0, trig_i.s5);
      m19_q <= mq(trig_i.s5, trig_i.cc);
      s0_1q <= trig_i.s0;
      c0_1q <= trig_i.c0;
      c1_1q <= trig_i.c1;
      cb_1q <= trig_i.cb;
      cc_1q <= trig_i.cc;
      sc_1q <= trig_i.sc;
      s4_1q <= trig_i.s4;
      dx_q  <= 23'(d2) - 23'(d1) - 23'(d3);
      dy_q  <= 23'(d1) - 23'(d2) + 23'(d3);
    end
  end

  // level 2: length products and second trig products
  logic signed [40:0] px1_q, py1_q;
  logic signed [38:0] px2_q, px3_q, px4_q, px5_q, py2_q, py3_q, py4_q, py5_q;
  logic signed [38:0] pz1_q, pz2_q, pz3_q, pz4_q;
  logic signed [17:0] n1_q, n2_q, n3_q, n4_q, n5_q, n6_q, n7_q, s0p_q, c0p_q, psc_q;
  logic signed [17:0] m11_2q, m13_2q, m19_2q, cc_2q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      px1_q  <= 41'(dx_q) * 41'(s0_1q);
      px2_q  <= 39'(l0) * 39'(m01_q);
      px3_q  <= 39'(l1) * 39'(m02_q);
      px4_q  <= 39'(d4) * 39'(m03_q);
      px5_q  <= 39'(d5) * 39'(m04_q);
      py1_q  <= 41'(dy_q) * 41'(c0_1q);
      py2_q  <= 39'(d5) * 39'(m06_q);
      py3_q  <= 39'(l0) * 39'(m07_q);
      py4_q  <= 39'(l1) * 39'(m08_q);
      py5_q  <= 39'(d4) * 39'(m09_q);
      pz1_q  <= 39'(l0) * 39'(c1_1q);
      pz2_q  <= 39'(l1) * 39'(cb_1q);
      pz3_q  <= 39'(d4) * 39'(cc_1q);
      pz4_q  <= 39'(d5) * 39'(m11_q);
      n1_q   <= mq(m05_q, cc_1q);
      n2_q   <= mq(m10_q, cc_1q);
      n3_q   <= mq(m14_q, sc_1q);
      n4_q   <= mq(m15_q, sc_1q);
      n5_q   <= mq(m16_q, s4_1q);
      n6_q   <= mq(m17_q, s4_1q);
      n7_q   <= mq(m18_q, sc_1q);
      s0p_q  <= mq(s0_1q, p_q);
      c0p_q  <= mq(c0_1q, p_q);
      psc_q  <= mq(p_q, sc_1q);
      m11_2q <= m11_q;
      m13_2q <= m13_q;
      m19_2q <= m19_q;
      cc_2q  <= cc_1q;
    end
  end

  // level 3: partial sums, last products
  logic signed [43:0] sx_q, sy_q, sz_q;
  logic signed [38:0] px6_q, py6_q;
  logic signed [17:0] n8_q, n9_q, n4_3q, n5_3q, n6_3q, n7_3q;
  logic signed [19:0] sphi_3q, cphi_3q, sp_3q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sx_q    <= 44'(px1_q) + 44'(px2_q) + 44'(px3_q) + 44'(px4_q) - 44'(px5_q);
      sy_q    <= 44'(py1_q) + 44'(py2_q) + 44'(py3_q) + 44'(py4_q) + 44'(py5_q);
      sz_q    <= (44'(d0) <<< 16) + 44'(pz1_q) + 44'(pz2_q) + 44'(pz3_q) + 44'(pz4_q);
      px6_q   <= 39'(d5) * 39'(n1_q);
      py6_q   <= 39'(d5) * 39'(n2_q);
      n8_q    <= mq(s0p_q, cc_2q);
      n9_q    <= mq(c0p_q, cc_2q);
      n4_3q   <= n4_q;
      n5_3q   <= n5_q;
      n6_3q   <= n6_q;
      n7_3q   <= n7_q;
      sphi_3q <= 20'(m13_2q) - 20'(n3_q);
      cphi_3q <= 20'(m11_2q);
      sp_3q   <= -(20'(m19_2q) + 20'(psc_q));
    end
  end

  // level 4: final sums
  logic signed [43:0] ax_q, ay_q, az_q;
  logic signed [19:0] st_q, ct_q, sphi_q, cphi_q, sp_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      ax_q   <= sx_q - 44'(px6_q);
      ay_q   <= sy_q - 44'(py6_q);
      az_q   <= sz_q;
      st_q   <= 20'(n4_3q) - 20'(n5_3q) - 20'(n8_q);
      ct_q   <= 20'(n6_3q) + 20'(n7_3q) - 20'(n9_q);
      sphi_q <= sphi_3q;
      cphi_q <= cphi_3q;
      sp_q   <= sp_3q;
    end
  end

  always_comb begin
    pose_o.pos_x    = pos_out(ax_q);
    pose_o.pos_y    = pos_out(ay_q);
    pose_o.pos_z    = pos_out(az_q);
    pose_o.sphi     = sphi_q;
    pose_o.cphi     = cphi_q;
    pose_o.st       = st_q;
    pose_o.ct       = ct_q;
    pose_o.sp       = sp_q;
    pose_o.singular = (ct_q == '0) && (st_q != '0);
  end

endmodule

/* hdl/fk_checker.sv */
// ----------------------------------------------------------------------------
// fk_checker
// port-level checks of the arm kinematics block, bound to the top level
// ----------------------------------------------------------------------------
module fk_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] pos_x_o,
  input logic signed [16:0] orient_psi_o,
  input logic signed [16:0] orient_theta_o,
  input logic               singular_o
);

  // stalled beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  // stalled payload holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pos_x_o) && $stable(orient_psi_o))
    else $error("output payload changed under stall");

  // singular pose gives zero psi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> orient_psi_o == 17'sd0)
    else $error("psi not zero in singular pose");

  // theta within half a turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (orient_theta_o <= 17'sd46080) && (orient_theta_o >= -17'sd46080))
    else $error("theta out of range");

endmodule

bind six_axis_arm_forward_kinematics fk_checker u_fk_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the arm forward kinematics block against an independent fixed-point
// predictor of position, orientation and the singular flag, under random
// idling and stalling on both channels and several geometry settings
// ----------------------------------------------------------------------------

class pose_board;
  typedef struct {
    logic signed [23:0] x, y, z;
    logic signed [16:0] phi, psi, theta;
    logic               sing;
  } pose_s;

  pose_s pending[$];
  int    errors;
  int    checked;
  int    singular_seen;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctab(int i);
    longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                      29, 14, 7, 4, 2, 1};
    return i < 23 ? t[i] : 0;
  endfunction

  function automatic void sin_cos(longint ang, output longint s, output longint c);
    longint r, x, y, z, nx;
    bit flip;
    r = ang % 92160;
    x = 39797;
    y = 0;
    flip = 0;
    if (r >= 46080) r -= 92160;
    if (r < -46080) r += 92160;
    if (r > 23040) begin
      r -= 46080;
      flip = 1;
    end else if (r < -23040) begin
      r += 46080;
      flip = 1;
    end
    z = r * 256;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        z -= arctab(i);
      end else begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        z += arctab(i);
      end
      x = nx;
    end
    x = lim(x, -65536, 65536);
    y = lim(y, -65536, 65536);
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint arc_tan2(longint y, longint x, output longint mag);
    longint base, z, nx;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      base = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        z += arctab(i);
      end else begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        z -= arctab(i);
      end
      x = nx;
    end
    mag = qmul(x, 39797);
    return base + z;
  endfunction

  function automatic logic signed [16:0] to_deg(longint z);
    return 17'(lim((z + 128) >>> 8, -46080, 46080));
  endfunction

  function automatic logic signed [23:0] to_mm(longint acc);
    return 24'(lim((acc + 32768) >>> 16, -8388608, 8388607));
  endfunction

  // predict the pose for one accepted beat of joint angles
  function void note_angles(longint g[8], longint q[6]);
    longint s0, c0, s1, c1, s4, c4, s5, c5, sb, cb, sc, cc;
    longint acc, p, sphi, cphi, st, ct, sp, mag, mag2, th, ph, ps;
    pose_s e;
    ps = 0;
    sin_cos(q[0], s0, c0);
    sin_cos(q[1], s1, c1);
    sin_cos(q[4], s4, c4);
    sin_cos(q[5], s5, c5);
    sin_cos(q[1] - q[2], sb, cb);
    sin_cos(q[1] - q[2] + q[3], sc, cc);
    acc = (g[2] - g[1] - g[3]) * s0 + g[6] * qmul(c0, s1) + g[7] * qmul(c0, sb)
        + g[4] * qmul(c0, sc) - g[5] * qmul(c4, s0) - g[5] * qmul(qmul(c0, s4), cc);
    e.x = to_mm(acc);
    acc = (g[1] - g[2] + g[3]) * c0 + g[5] * qmul(c0, c4) + g[6] * qmul(s0, s1)
        + g[7] * qmul(s0, sb) + g[4] * qmul(s0, sc) - g[5] * qmul(qmul(s0, s4), cc);
    e.y = to_mm(acc);
    acc = g[0] * 65536 + g[6] * c1 + g[7] * cb + g[4] * cc + g[5] * qmul(s4, sc);
    e.z = to_mm(acc);
    p = qmul(c4, c5);
    sphi = qmul(c5, cc) - qmul(qmul(s5, c4), sc);
    cphi = qmul(s4, sc);
    st = qmul(qmul(s0, s5), sc) - qmul(qmul(c0, c5), s4) - qmul(qmul(s0, p), cc);
    ct = qmul(qmul(c5, s0), s4) + qmul(qmul(c0, s5), sc) - qmul(qmul(c0, p), cc);
    sp = -(qmul(s5, cc) + qmul(p, sc));
    ph = arc_tan2(sphi, cphi, mag2);
    th = arc_tan2(st, ct, mag);
    e.sing = (ct == 0 && st != 0);
    if (!e.sing) ps = arc_tan2(sp, mag, mag2);
    e.phi = to_deg(ph);
    e.psi = to_deg(ps);
    e.theta = to_deg(th);
    pending.push_back(e);
  endfunction

  function void check_pose(pose_s a);
    pose_s e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat x=%0d y=%0d z=%0d", $time, a.x, a.y, a.z);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (a.sing) singular_seen++;
    if (a.x !== e.x) begin
      $display("%0t: pos_x expected %0d actual %0d", $time, e.x, a.x);
      errors++;
    end
    if (a.y !== e.y) begin
      $display("%0t: pos_y expected %0d actual %0d", $time, e.y, a.y);
      errors++;
    end
    if (a.z !== e.z) begin
      $display("%0t: pos_z expected %0d actual %0d", $time, e.z, a.z);
      errors++;
    end
    if (a.phi !== e.phi) begin
      $display("%0t: orient_phi expected %0d actual %0d", $time, e.phi, a.phi);
      errors++;
    end
    if (a.psi !== e.psi) begin
      $display("%0t: orient_psi expected %0d actual %0d", $time, e.psi, a.psi);
      errors++;
    end
    if (a.theta !== e.theta) begin
      $display("%0t: orient_theta expected %0d actual %0d", $time, e.theta, a.theta);
      errors++;
    end
    if (a.sing !== e.sing) begin
      $display("%0t: singular expected %0b actual %0b", $time, e.sing, a.sing);
      errors++;
    end
  endfunction
endclass

module testbench;
  import fk_pkg::*;

  localparam int LATENCY   = 3 * 16 + 7;
  localparam int MAX_CYCLE = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [17:0] joint[6];
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [23:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [16:0] orient_phi_o, orient_psi_o, orient_theta_o;
  logic               singular_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  reg_idx_e           cfg_index_i;
  logic [20:0]        cfg_data_i;

  pose_board board;
  longint    geom[8];     // geometry as the predictor sees it
  int        send_idle;   // percent of cycles the sender stays idle
  int        stall_pct;   // percent of cycles the receiver stalls
  int        hold_off;    // long receiver hold-off, cycles left
  int        cycle;
  int        settings_run;
  bit        timed_out;

  six_axis_arm_forward_kinematics DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .joint_angle_0_i(joint[0]), .joint_angle_1_i(joint[1]),
    .joint_angle_2_i(joint[2]), .joint_angle_3_i(joint[3]),
    .joint_angle_4_i(joint[4]), .joint_angle_5_i(joint[5]),
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .pos_z_o,
    .orient_phi_o, .orient_psi_o, .orient_theta_o, .singular_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // cycle limit, ends a hung run
  initial begin
    cycle = 0;
    timed_out = 0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle > MAX_CYCLE) begin
        timed_out = 1;
        $display("timeout at cycle %0d", cycle);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_stall_i = 1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_pose('{pos_x_o, pos_y_o, pos_z_o, orient_phi_o, orient_psi_o,
                           orient_theta_o, singular_o});
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // one register write; the caller drops cfg_valid_i after the last one
  task automatic write_reg(reg_idx_e idx, longint val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= 21'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    geom[idx] = longint'($signed(21'(val)));
  endtask

  // one beat of joint angles, idles before it as the phase asks
  task automatic send_angles(longint a[6]);
    longint q[6];
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    for (int i = 0; i < 6; i++) begin
      joint[i] <= 18'(a[i]);
      q[i] = longint'($signed(18'(a[i])));
    end
    do @(posedge clk_i); while (in_stall_o);
    board.note_angles(geom, q);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic longint rand_angle();
    case ($urandom_range(9))
      0:       return $urandom_range(3) == 0 ? -131072 + $urandom_range(262143) : 0;
      1:       return ($urandom_range(7) - 4) * 23040;   // right angles
      default: return longint'($urandom_range(184320)) - 92160;
    endcase
  endfunction

  task automatic random_block(int count);
    longint a[6];
    repeat (count) begin
      for (int i = 0; i < 6; i++) a[i] = rand_angle();
      send_angles(a);
    end
  endtask

  // set all eight registers, idle block only
  task automatic load_geometry(int mode);
    for (int r = 0; r < 8; r++) begin
      case (mode)
        0:       write_reg(reg_idx_e'(r), 1048575);
        1:       write_reg(reg_idx_e'(r), -1048576);
        2:       write_reg(reg_idx_e'(r), longint'($urandom_range(2097151)) - 1048576);
        default: write_reg(reg_idx_e'(r), longint'($urandom_range(120000)) - 60000);
      endcase
    end
    cfg_valid_i <= 0;
    settings_run++;
  endtask

  initial begin
    longint a[6];
    longint dir[6];
    board = new();
    foreach (geom[i]) geom[i] = 0;
    rst_ni = 0;
    in_valid_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = REG_D0;
    cfg_data_i = '0;
    foreach (joint[i]) joint[i] = '0;
    send_idle = 0;
    stall_pct = 0;
    hold_off = 0;
    settings_run = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset geometry then typical geometry, field extremes,
    // wrap of out-of-range angles, right angles for singular poses
    random_block(2);
    drain();
    load_geometry(3);
    dir = '{0, 0, 0, 0, 0, 0};
    send_angles(dir);
    dir = '{92160, -92160, 92160, -92160, 92160, -92160};
    send_angles(dir);
    dir = '{131071, -131072, 131071, -131072, 131071, -131072};
    send_angles(dir);
    dir = '{-131072, 131071, -131072, 131071, -131072, 131071};
    send_angles(dir);
    dir = '{46080, 46080, -46080, 46080, -46080, 46080};
    send_angles(dir);
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 6; i++) a[i] = ($urandom_range(7) - 4) * 23040;
      send_angles(a);
    end
    dir = '{0, 23040, 0, 0, 23040, 0};
    send_angles(dir);
    dir = '{23040, 0, 23040, -23040, 0, 23040};
    send_angles(dir);
    dir = '{1, -1, 1, -1, 1, -1};
    send_angles(dir);
    drain();

    // random phases with varied idling and geometry, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      load_geometry(ph % 4);
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 55; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 55; end
        default: begin send_idle = 13; stall_pct = 13; end
      endcase
      if (ph == 2) hold_off = 400;   // receiver holds off, block fills up
      random_block(60);
      drain();                       // sender waits for every result
    end
    send_idle = 0;
    stall_pct = 0;
    drain();

    $display("checked %0d result beats over %0d geometry settings, %0d singular",
             board.checked, settings_run, board.singular_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
